@@ rtl/wavelength_budget_allocator_unit_assert.svh @@
// Assertion macros for the wavelength budget allocator.
`ifndef WAVELENGTH_BUDGET_ALLOCATOR_UNIT_ASSERT_SVH
`define WAVELENGTH_BUDGET_ALLOCATOR_UNIT_ASSERT_SVH

// Checked out of reset only.
`define WBA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define WBA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wba_pkg.sv @@
package wba_pkg;

  localparam int MODE_W = 2;
  localparam int MOD_W  = 2;
  localparam int LOC_W  = 4;
  localparam int CNT_W  = 4;

  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASSIGN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

  localparam logic [CNT_W-1:0] LAMBDA_RESET = 4'd10;
  localparam logic [CNT_W-1:0] CNT_MAX      = 4'd15;

  // Per-item control sent from the top to the state holders.
  typedef struct packed {
    logic commit;   // item leaves stage 1 this cycle, state updates
    logic restart;  // item is a restart
  } cmd_t;

  // Budget lookup result for the item in stage 1.
  typedef struct packed {
    logic             granted;
    logic             fiber_exhausted;
    logic [CNT_W-1:0] fiber_remaining;
  } stat_t;

endpackage

@@ rtl/wba_chan_if.sv @@
interface wba_req_if;
  logic                       valid;
  logic                       ready;
  logic [wba_pkg::MODE_W-1:0] mode;
  logic [wba_pkg::MOD_W-1:0]  in_module;
  logic [wba_pkg::MOD_W-1:0]  out_module;
  logic [wba_pkg::LOC_W-1:0]  location;

  modport source (output valid, output mode, output in_module, output out_module,
                  output location, input ready);
  modport sink   (input valid, input mode, input in_module, input out_module,
                  input location, output ready);
endinterface

interface wba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      granted;
  logic                      fiber_exhausted;
  logic [wba_pkg::CNT_W-1:0] pair_count;
  logic [wba_pkg::CNT_W-1:0] fiber_remaining;

  modport source (output valid, output granted, output fiber_exhausted,
                  output pair_count, output fiber_remaining, input ready);
  modport sink   (input valid, input granted, input fiber_exhausted,
                  input pair_count, input fiber_remaining, output ready);
endinterface

@@ rtl/wba_pair_store.sv @@
module wba_pair_store #(
  parameter int PORTS_PER_MODULE = 4,
  parameter int MODULE_COUNT     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [$clog2(PORTS_PER_MODULE*MODULE_COUNT)-1:0] rd_addr_i,
  input  wba_pkg::cmd_t              cmd_i,
  input  logic                       grant_i,
  input  logic [$clog2(PORTS_PER_MODULE*MODULE_COUNT)-1:0] src_i,
  input  logic [$clog2(PORTS_PER_MODULE*MODULE_COUNT)-1:0] dst_i,
  output logic [wba_pkg::CNT_W-1:0]  count_o
);

  localparam int SW_N = PORTS_PER_MODULE * MODULE_COUNT;
  localparam int CW   = wba_pkg::CNT_W;

  typedef logic [SW_N-1:0][CW-1:0] row_t;

  // One row per source switch, one count per destination switch.
  row_t pair_mem_q [SW_N];
  row_t rd_row_q;
  row_t byp_row_q;
  logic byp_q, byp_d;
  logic [SW_N-1:0] valid_q, valid_d;

  row_t           row_cur;
  row_t           wr_row;
  logic [CW-1:0]  cur;
  logic           inc;
  logic           wr_en;

  assign wr_en = cmd_i.commit && grant_i;

  always_comb begin
    if (!valid_q[src_i]) begin
      row_cur = '0;
    end else if (byp_q) begin
      row_cur = byp_row_q;
    end else begin
      row_cur = rd_row_q;
    end
    cur     = row_cur[dst_i];
    inc     = grant_i && (cur != wba_pkg::CNT_MAX);
    count_o = cur + CW'(inc);
    wr_row  = row_cur;
    wr_row[dst_i] = count_o;
  end

  // Write in the same edge as a read of the same row: forward the new row.
  assign byp_d = wr_en && (src_i == rd_addr_i);

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.commit && cmd_i.restart) begin
      valid_d = '0;
    end else if (wr_en) begin
      valid_d[src_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (rd_en_i) begin
        byp_q <= byp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem_q[src_i] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_q  <= pair_mem_q[rd_addr_i];
      byp_row_q <= wr_row;
    end
  end

endmodule

@@ rtl/wba_budget.sv @@
module wba_budget #(
  parameter int PORTS_PER_MODULE = 4,
  parameter int MODULE_COUNT     = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wba_pkg::CNT_W-1:0]           lam_i,
  input  wba_pkg::cmd_t                       cmd_i,
  input  logic                                attempt_i,
  input  logic                                mod_ok_i,
  input  logic                                pair_ok_i,
  input  logic [$clog2(MODULE_COUNT)-1:0]     im_i,
  input  logic [$clog2(MODULE_COUNT)-1:0]     om_i,
  input  logic [$clog2(PORTS_PER_MODULE)-1:0] sp_i,
  input  logic [$clog2(PORTS_PER_MODULE)-1:0] dp_i,
  output wba_pkg::stat_t                      stat_o
);

  localparam int CW = wba_pkg::CNT_W;
  localparam int PW = $clog2(PORTS_PER_MODULE);

  // Rows by module: transmit by input module, receive by output module,
  // fiber by input module with one counter per output module.
  logic [PORTS_PER_MODULE-1:0][CW-1:0] tx_q [MODULE_COUNT];
  logic [PORTS_PER_MODULE-1:0][CW-1:0] tx_d [MODULE_COUNT];
  logic [PORTS_PER_MODULE-1:0][CW-1:0] rx_q [MODULE_COUNT];
  logic [PORTS_PER_MODULE-1:0][CW-1:0] rx_d [MODULE_COUNT];
  logic [MODULE_COUNT-1:0][CW-1:0]     fib_q [MODULE_COUNT];
  logic [MODULE_COUNT-1:0][CW-1:0]     fib_d [MODULE_COUNT];

  logic [PORTS_PER_MODULE-1:0][CW-1:0] tx_row, rx_row;
  logic [MODULE_COUNT-1:0][CW-1:0]     fib_row;
  logic [CW-1:0] tx_cur, rx_cur, fib_cur, remaining;
  logic          grant, tx_any, rx_any;

  always_comb begin
    tx_row  = tx_q[im_i];
    rx_row  = rx_q[om_i];
    fib_row = fib_q[im_i];
    tx_cur  = tx_row[sp_i];
    rx_cur  = rx_row[dp_i];
    fib_cur = fib_row[om_i];
    grant   = attempt_i && mod_ok_i && pair_ok_i &&
              (tx_cur != '0) && (rx_cur != '0) && (fib_cur != '0);
  end

  // Group still has budget after this item's decrement.
  always_comb begin
    tx_any = 1'b0;
    rx_any = 1'b0;
    for (int p = 0; p < PORTS_PER_MODULE; p++) begin
      if (grant && (PW'(p) == sp_i)) begin
        tx_any = tx_any | (tx_row[p] != CW'(1));
      end else begin
        tx_any = tx_any | (tx_row[p] != '0);
      end
      if (grant && (PW'(p) == dp_i)) begin
        rx_any = rx_any | (rx_row[p] != CW'(1));
      end else begin
        rx_any = rx_any | (rx_row[p] != '0);
      end
    end
  end

  always_comb begin
    if (cmd_i.restart) begin
      remaining              = lam_i;
      stat_o.fiber_exhausted = (lam_i == '0);
    end else begin
      remaining              = fib_cur - CW'(grant);
      stat_o.fiber_exhausted = (remaining == '0) || !tx_any || !rx_any;
    end
    stat_o.granted         = grant;
    stat_o.fiber_remaining = remaining;
  end

  always_comb begin
    tx_d  = tx_q;
    rx_d  = rx_q;
    fib_d = fib_q;
    if (cmd_i.commit && cmd_i.restart) begin
      for (int m = 0; m < MODULE_COUNT; m++) begin
        for (int p = 0; p < PORTS_PER_MODULE; p++) begin
          tx_d[m][p] = lam_i;
          rx_d[m][p] = lam_i;
        end
        for (int o = 0; o < MODULE_COUNT; o++) begin
          fib_d[m][o] = lam_i;
        end
      end
    end else if (cmd_i.commit && grant) begin
      tx_d[im_i][sp_i]  = tx_cur - CW'(1);
      rx_d[om_i][dp_i]  = rx_cur - CW'(1);
      fib_d[im_i][om_i] = fib_cur - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < MODULE_COUNT; m++) begin
        for (int p = 0; p < PORTS_PER_MODULE; p++) begin
          tx_q[m][p] <= wba_pkg::LAMBDA_RESET;
          rx_q[m][p] <= wba_pkg::LAMBDA_RESET;
        end
        for (int o = 0; o < MODULE_COUNT; o++) begin
          fib_q[m][o] <= wba_pkg::LAMBDA_RESET;
        end
      end
    end else begin
      tx_q  <= tx_d;
      rx_q  <= rx_d;
      fib_q <= fib_d;
    end
  end

endmodule

@@ rtl/wavelength_budget_allocator_unit.sv @@
// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   mode, in_module, out_module, location
// rsp_o     out  valid/ready   granted, fiber_exhausted, pair_count, fiber_remaining
// cfg       in   cfg_we_i      cfg_wdata_i = lambdas_per_fiber
//
// One item per cycle sustained while rsp_o.ready holds; path: stage 1 register, then result register.
// Stage 1 holds the decoded request and the pair-count row read from the RAM at
// acceptance; budget lookup, grant and update all settle before the result register.
// Reset: budgets load to 10 and pair counts read as zero at once (row valid bits).
// A result not taken holds the result register, then stage 1, then drops req_i.ready.
`include "wavelength_budget_allocator_unit_assert.svh"

module wavelength_budget_allocator_unit #(
  parameter int PORTS_PER_MODULE = 4,
  parameter int MODULE_COUNT     = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wba_pkg::CNT_W-1:0] cfg_wdata_i,
  wba_req_if.sink                   req_i,
  wba_rsp_if.source                 rsp_o
);

  localparam int SW_N = PORTS_PER_MODULE * MODULE_COUNT;
  localparam int AW   = $clog2(SW_N);
  localparam int MW   = $clog2(MODULE_COUNT);
  localparam int PW   = $clog2(PORTS_PER_MODULE);
  localparam int CW   = wba_pkg::CNT_W;
  localparam int LW   = wba_pkg::LOC_W;

  // location / PORTS_PER_MODULE by compares against constant multiples.
  function automatic logic [LW-1:0] port_quot(input logic [LW-1:0] loc);
    logic [LW-1:0] q;
    q = '0;
    for (int k = 1; k < (1 << LW); k++) begin
      if (int'(loc) >= k * PORTS_PER_MODULE) begin
        q = q + LW'(1);
      end
    end
    return q;
  endfunction

  // Configuration
  logic [CW-1:0] lam_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lam_q <= wba_pkg::LAMBDA_RESET;
    end else if (cfg_we_i) begin
      lam_q <= cfg_wdata_i;
    end
  end

  // Handshake and flow
  logic accept, adv, req_ready;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  assign adv         = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_ready   = !s1_valid_q || adv;
  assign accept      = req_i.valid && req_ready;
  assign req_i.ready = req_ready;

  always_comb begin
    s1_valid_d  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_q);
    out_valid_d = adv ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  // Input decode: split location, range-check module and port indexes.
  logic [LW-1:0] quot, rem;
  logic          mod_ok_in, pair_ok_in;
  logic [MW-1:0] im_in, om_in;
  logic [PW-1:0] sp_in, dp_in;
  logic [AW-1:0] src_in, dst_in;

  always_comb begin
    quot       = port_quot(req_i.location);
    rem        = LW'(int'(req_i.location) - int'(quot) * PORTS_PER_MODULE);
    pair_ok_in = int'(quot) < PORTS_PER_MODULE;
    mod_ok_in  = (int'(req_i.in_module) < MODULE_COUNT) &&
                 (int'(req_i.out_module) < MODULE_COUNT);
    im_in      = mod_ok_in ? MW'(req_i.in_module) : '0;
    om_in      = mod_ok_in ? MW'(req_i.out_module) : '0;
    sp_in      = pair_ok_in ? PW'(quot) : '0;
    dp_in      = PW'(rem);
    src_in     = AW'(int'(im_in) * PORTS_PER_MODULE + int'(sp_in));
    dst_in     = AW'(int'(om_in) * PORTS_PER_MODULE + int'(dp_in));
  end

  // Stage 1 register
  logic [wba_pkg::MODE_W-1:0] s1_mode_q;
  logic                       s1_mod_ok_q, s1_pair_ok_q;
  logic [MW-1:0]              s1_im_q, s1_om_q;
  logic [PW-1:0]              s1_sp_q, s1_dp_q;
  logic [AW-1:0]              s1_src_q, s1_dst_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q    <= req_i.mode;
      s1_mod_ok_q  <= mod_ok_in;
      s1_pair_ok_q <= pair_ok_in;
      s1_im_q      <= im_in;
      s1_om_q      <= om_in;
      s1_sp_q      <= sp_in;
      s1_dp_q      <= dp_in;
      s1_src_q     <= src_in;
      s1_dst_q     <= dst_in;
    end
  end

  // Stage 1 work
  wba_pkg::cmd_t  cmd;
  wba_pkg::stat_t stat;
  logic           attempt;
  logic [CW-1:0]  pair_cnt;

  assign cmd.commit  = adv;
  assign cmd.restart = (s1_mode_q == wba_pkg::MODE_RESTART);
  assign attempt     = (s1_mode_q == wba_pkg::MODE_ASSIGN);

  wba_budget #(
    .PORTS_PER_MODULE (PORTS_PER_MODULE),
    .MODULE_COUNT     (MODULE_COUNT)
  ) u_budget (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lam_i     (lam_q),
    .cmd_i     (cmd),
    .attempt_i (attempt),
    .mod_ok_i  (s1_mod_ok_q),
    .pair_ok_i (s1_pair_ok_q),
    .im_i      (s1_im_q),
    .om_i      (s1_om_q),
    .sp_i      (s1_sp_q),
    .dp_i      (s1_dp_q),
    .stat_o    (stat)
  );

  wba_pair_store #(
    .PORTS_PER_MODULE (PORTS_PER_MODULE),
    .MODULE_COUNT     (MODULE_COUNT)
  ) u_pair_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (src_in),
    .cmd_i     (cmd),
    .grant_i   (stat.granted),
    .src_i     (s1_src_q),
    .dst_i     (s1_dst_q),
    .count_o   (pair_cnt)
  );

  // Result: no fiber addressed overrides everything; restart and a bad
  // port pair report a zero count.
  logic          rsp_granted_d, rsp_exh_d;
  logic [CW-1:0] rsp_count_d, rsp_rem_d;
  logic          rsp_granted_q, rsp_exh_q;
  logic [CW-1:0] rsp_count_q, rsp_rem_q;

  always_comb begin
    if (!s1_mod_ok_q) begin
      rsp_granted_d = 1'b0;
      rsp_exh_d     = 1'b1;
      rsp_count_d   = '0;
      rsp_rem_d     = '0;
    end else begin
      rsp_granted_d = stat.granted;
      rsp_exh_d     = stat.fiber_exhausted;
      rsp_count_d   = (!s1_pair_ok_q || cmd.restart) ? '0 : pair_cnt;
      rsp_rem_d     = stat.fiber_remaining;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rsp_granted_q <= rsp_granted_d;
      rsp_exh_q     <= rsp_exh_d;
      rsp_count_q   <= rsp_count_d;
      rsp_rem_q     <= rsp_rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.granted         = rsp_granted_q;
  assign rsp_o.fiber_exhausted = rsp_exh_q;
  assign rsp_o.pair_count      = rsp_count_q;
  assign rsp_o.fiber_remaining = rsp_rem_q;

  // Assertions
  `WBA_ASSERT(a_ready_low_only_when_full, clk_i, rst_ni, !req_ready |-> (s1_valid_q && out_valid_q && !rsp_o.ready), "req ready low while pipeline can move")
  `WBA_ASSERT(a_grant_only_on_assign, clk_i, rst_ni, (adv && (s1_mode_q != wba_pkg::MODE_ASSIGN)) |=> !rsp_granted_q, "grant on a non-assign item")
  `WBA_ASSERT(a_no_fiber_result, clk_i, rst_ni, (adv && !s1_mod_ok_q) |=> (rsp_exh_q && !rsp_granted_q && (rsp_rem_q == '0) && (rsp_count_q == '0)), "bad result for unaddressed fiber")
  `WBA_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> (!s1_valid_q && !out_valid_q), "pipeline not empty in reset")

endmodule

@@ sim/wavelength_budget_allocator_unit_tb.sv @@
`timescale 1ns / 1ps

module wavelength_budget_allocator_unit_tb;

  // Field widths from the package.
  localparam int MODE_W = wba_pkg::MODE_W;
  localparam int MOD_W  = wba_pkg::MOD_W;
  localparam int LOC_W  = wba_pkg::LOC_W;
  localparam int CNT_W  = wba_pkg::CNT_W;

  // Block geometry, kept at the defaults of the block.
  localparam int PORTS   = 4;
  localparam int MODULES = 4;
  localparam int SWITCH_N = PORTS * MODULES;

  // The one mode value that has no name in the package; the block treats it as a read.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Pipeline depth is two registers; the extra drain covers the settle.
  localparam int DRAIN_CYCLES = 4;
  // Cycles with no item moving on either channel before the run is called hung.
  localparam int IDLE_LIMIT = 2000;
  // Cap on mismatch lines so a broken block does not flood the log.
  localparam int MAX_REPORTS = 60;

  typedef struct packed {
    logic             granted;
    logic             fiber_exhausted;
    logic [CNT_W-1:0] pair_count;
    logic [CNT_W-1:0] fiber_remaining;
  } rsp_item_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  wba_req_if req_if ();
  wba_rsp_if rsp_if ();

  wavelength_budget_allocator_unit #(
    .PORTS_PER_MODULE (PORTS),
    .MODULE_COUNT     (MODULES)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the allocator state. Every budget is a 4-bit down counter, the
  // pair table is a 4-bit saturating up counter per (src switch, dst switch).
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] lambda_load;      // register value, applied at the next restart
  logic [CNT_W-1:0] tx_budget    [SWITCH_N];
  logic [CNT_W-1:0] rx_budget    [SWITCH_N];
  logic [CNT_W-1:0] fiber_budget [MODULES][MODULES];
  logic [CNT_W-1:0] pair_lambdas [SWITCH_N][SWITCH_N];

  rsp_item_t expected_rsp_q [$];

  int  errors;
  int  idle_cycles;
  int  burst_left;
  bit  full_rate;      // no sender gaps, receiver always ready

  // Restart semantics: every budget back to the register value, pair counts cleared.
  function automatic void reload_budgets();
    for (int s = 0; s < SWITCH_N; s++) begin
      tx_budget[s] = lambda_load;
      rx_budget[s] = lambda_load;
      for (int d = 0; d < SWITCH_N; d++) begin
        pair_lambdas[s][d] = '0;
      end
    end
    for (int i = 0; i < MODULES; i++) begin
      for (int o = 0; o < MODULES; o++) begin
        fiber_budget[i][o] = lambda_load;
      end
    end
  endfunction

  // One request through the allocator: updates the shadow and returns the result.
  function automatic rsp_item_t allocate_step(logic [MODE_W-1:0] mode,
                                              logic [MOD_W-1:0] im,
                                              logic [MOD_W-1:0] om,
                                              logic [LOC_W-1:0] loc);
    rsp_item_t r;
    int sp;
    int dp;
    int s;
    int d;
    bit tx_any;
    bit rx_any;
    r  = '0;
    sp = int'(loc) / PORTS;
    dp = int'(loc) % PORTS;
    if (mode == wba_pkg::MODE_RESTART) begin
      reload_budgets();
    end
    // No fiber behind an out-of-range module index.
    if (int'(im) >= MODULES || int'(om) >= MODULES) begin
      r.fiber_exhausted = 1'b1;
      return r;
    end
    if (sp < PORTS) begin
      s = int'(im) * PORTS + sp;
      d = int'(om) * PORTS + dp;
      if (mode == wba_pkg::MODE_ASSIGN && tx_budget[s] != 0 && rx_budget[d] != 0 &&
          fiber_budget[im][om] != 0) begin
        tx_budget[s]--;
        rx_budget[d]--;
        fiber_budget[im][om]--;
        if (pair_lambdas[s][d] != wba_pkg::CNT_MAX) begin
          pair_lambdas[s][d]++;
        end
        r.granted = 1'b1;
      end
      r.pair_count = pair_lambdas[s][d];
    end
    // Fiber is dead when its own budget is gone or either switch group is drained.
    tx_any = 1'b0;
    rx_any = 1'b0;
    for (int p = 0; p < PORTS; p++) begin
      if (tx_budget[int'(im) * PORTS + p] != 0) tx_any = 1'b1;
      if (rx_budget[int'(om) * PORTS + p] != 0) rx_any = 1'b1;
    end
    r.fiber_remaining = fiber_budget[im][om];
    r.fiber_exhausted = (r.fiber_remaining == 0) || !tx_any || !rx_any;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is applied once.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready follows a 16-bit mask that is rotated every cycle and
  // redrawn when its age counter runs out. Bit 0 is forced so every stall ends within a turn of the mask;
  // some masks are all ones to give stall-free stretches.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] stall_mask;
    int          mask_age;
    rsp_if.ready = 1'b0;
    stall_mask   = 16'hffff;
    mask_age     = 0;
    forever begin
      @(negedge clk_i);
      if (mask_age == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_mask = 16'hffff;
          1:       stall_mask = 16'($urandom) & 16'($urandom);   // mostly stalled
          default: stall_mask = 16'($urandom) | 16'($urandom);   // mostly ready
        endcase
        stall_mask[0] = 1'b1;
        mask_age = 48;
      end
      mask_age--;
      stall_mask   = {stall_mask[14:0], stall_mask[15]};
      rsp_if.ready = full_rate ? 1'b1 : stall_mask[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each result taken off rsp is matched against the oldest
  // prediction, field by field.
  // ---------------------------------------------------------------------------
  task automatic check_field(string field, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    rsp_item_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      if (expected_rsp_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("%0t: result with none expected, expected nothing, actual %h", $time,
                   {rsp_if.granted, rsp_if.fiber_exhausted, rsp_if.pair_count,
                    rsp_if.fiber_remaining});
        end
      end else begin
        want = expected_rsp_q.pop_front();
        check_field("granted", CNT_W'(want.granted), CNT_W'(rsp_if.granted));
        check_field("fiber_exhausted", CNT_W'(want.fiber_exhausted),
                    CNT_W'(rsp_if.fiber_exhausted));
        check_field("pair_count", want.pair_count, rsp_if.pair_count);
        check_field("fiber_remaining", want.fiber_remaining, rsp_if.fiber_remaining);
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one request item. Items go out in bursts of random length with
  // random gaps in between, unless full_rate is set. The prediction is made
  // at the edge where the item is accepted.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic [MODE_W-1:0] mode, logic [MOD_W-1:0] im,
                           logic [MOD_W-1:0] om, logic [LOC_W-1:0] loc);
    int gap;
    rsp_item_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (full_rate || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid      = 1'b1;
    req_if.mode       = mode;
    req_if.in_module  = im;
    req_if.out_module = om;
    req_if.location   = loc;
    do @(posedge clk_i); while (!req_if.ready);
    pred = allocate_step(mode, im, om, loc);
    expected_rsp_q = {expected_rsp_q, pred};
  endtask

  // Drop valid and hold off until every prediction has been matched, then let
  // the pipeline settle.
  task automatic wait_for_results();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only with the block idle. Takes effect at the next restart.
  task automatic set_budget(logic [CNT_W-1:0] value);
    wait_for_results();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    lambda_load = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset budgets, reads, the spare mode, both extremes of every field, restart.
  task automatic test_reset_state();
    send_item(wba_pkg::MODE_READ,    2'd0, 2'd0, 4'd0);
    send_item(MODE_SPARE,            2'd3, 2'd3, 4'd15);
    send_item(wba_pkg::MODE_ASSIGN,  2'd0, 2'd0, 4'd0);
    send_item(wba_pkg::MODE_ASSIGN,  2'd3, 2'd3, 4'd15);
    send_item(wba_pkg::MODE_READ,    2'd3, 2'd3, 4'd15);
    send_item(wba_pkg::MODE_RESTART, 2'd1, 2'd2, 4'd5);
  endtask

  // Budget of zero: after a restart every attempt fails and every fiber is dead.
  task automatic test_zero_budget();
    set_budget('0);
    send_item(wba_pkg::MODE_RESTART, 2'd0, 2'd0, 4'd0);
    send_item(wba_pkg::MODE_ASSIGN,  2'd0, 2'd0, 4'd0);
    send_item(wba_pkg::MODE_READ,    2'd2, 2'd1, 4'd9);
  endtask

  // Full budget on one pair: fifteen grants, then the source runs dry.
  task automatic test_pair_limit();
    set_budget(wba_pkg::CNT_MAX);
    send_item(wba_pkg::MODE_RESTART, 2'd1, 2'd1, 4'd6);
    repeat (16) send_item(wba_pkg::MODE_ASSIGN, 2'd1, 2'd1, 4'd6);
  endtask

  // Random traffic under one budget. Mostly attempts on a few hot modules so
  // budgets drain and fibers exhaust; reads, spare-mode reads and restarts mixed in.
  task automatic test_random_traffic(logic [CNT_W-1:0] budget, int items, int hot_span,
                                     bit pause_mid);
    int pick;
    logic [MODE_W-1:0] mode;
    set_budget(budget);
    send_item(wba_pkg::MODE_RESTART, MOD_W'($urandom), MOD_W'($urandom),
              LOC_W'($urandom));
    for (int n = 0; n < items; n++) begin
      if (pause_mid && n == items / 2) begin
        wait_for_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 3)       mode = wba_pkg::MODE_RESTART;
      else if (pick < 13) mode = wba_pkg::MODE_READ;
      else if (pick < 16) mode = MODE_SPARE;
      else                mode = wba_pkg::MODE_ASSIGN;
      if ($urandom_range(0, 4) == 0) begin
        send_item(mode, MOD_W'($urandom), MOD_W'($urandom), LOC_W'($urandom));
      end else begin
        send_item(mode, MOD_W'($urandom_range(0, hot_span)),
                  MOD_W'($urandom_range(0, hot_span)), LOC_W'($urandom));
      end
    end
  endtask

  // A stretch with no idling on either side.
  task automatic test_back_to_back();
    wait_for_results();
    full_rate = 1'b1;
    test_random_traffic(4'd3, 60, 1, 1'b0);
    wait_for_results();
    full_rate = 1'b0;
  endtask

  initial begin
    errors      = 0;
    burst_left  = 0;
    full_rate   = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    req_if.valid      = 1'b0;
    req_if.mode       = wba_pkg::MODE_READ;
    req_if.in_module  = '0;
    req_if.out_module = '0;
    req_if.location   = '0;
    lambda_load = wba_pkg::LAMBDA_RESET;
    reload_budgets();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_zero_budget();
    test_pair_limit();

    test_random_traffic(4'd1, 150, 1, 1'b0);
    test_random_traffic(4'd2, 150, 1, 1'b0);
    test_random_traffic(4'd3, 200, 3, 1'b0);
    test_random_traffic(wba_pkg::CNT_MAX, 200, 1, 1'b0);
    test_random_traffic(CNT_W'($urandom_range(1, 14)), 200, 3, 1'b0);
    test_random_traffic(4'd4, 200, 3, 1'b1);
    test_back_to_back();
    test_random_traffic(CNT_W'($urandom), 150, 3, 1'b0);

    // Drain everything and let the pipeline settle.
    wait_for_results();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
